// ----- sv/flash_firmware_partition_scanner_core_assert.svh -----
// Assertion macros shared by the flash firmware partition scanner RTL.
`ifndef FLASH_FIRMWARE_PARTITION_SCANNER_CORE_ASSERT_SVH
`define FLASH_FIRMWARE_PARTITION_SCANNER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/ffps_pkg.sv -----
// Package with constants and types of the flash firmware partition scanner.
package ffps_pkg;

	localparam logic [31:0] SCAN_STEP       = 32'd4096;
	localparam logic [31:0] CFG_SLICE_BYTES = 32'd65536;
	localparam logic [31:0] CFG_ALIGN_MASK  = ~(CFG_SLICE_BYTES - 32'd1);
	localparam logic [31:0] SECTOR_MASK     = 32'h0000_01FF;
	localparam logic [31:0] FLASH_BYTES_RST = 32'd16777216;
	localparam logic [31:0] NO_IMAGE_START  = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_SCAN    = 2'd0;
	localparam logic [1:0] MODE_HEADER  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [2:0] KIND_FOUND      = 3'd0;
	localparam logic [2:0] KIND_NOT_FOUND  = 3'd1;
	localparam logic [2:0] KIND_ROOTFS     = 3'd2;
	localparam logic [2:0] KIND_CFG        = 3'd3;
	localparam logic [2:0] KIND_MISALIGNED = 3'd4;
	localparam logic [2:0] KIND_NO_IMAGE   = 3'd5;

	localparam logic [1:0] REG_FLASH_BYTES = 2'd0;
	localparam logic [1:0] REG_IMAGE_MAGIC = 2'd1;
	localparam logic [1:0] REG_AUX_FIRST   = 2'd2;
	localparam logic [1:0] REG_AUX_SECOND  = 2'd3;

	localparam int OUT_DEPTH   = 4;
	localparam int OUT_PTR_W   = 2;
	localparam int OUT_CNT_W   = 3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] base;
		logic [31:0] length;
		logic [31:0] image_end;
		logic        last;
	} result_t;

endpackage

// ----- sv/flash_firmware_partition_scanner_core.sv -----
// Top level of the flash firmware partition scanner.
//
// The input channel takes one word per handshake: mode 0 carries a sampled flash
// word, mode 1 carries the image length and filesystem offset header words, and
// mode 2 restarts the scan. The output channel returns result words (found, not
// found, rootfs slice, cfg slice, misaligned, no image), with last set on the
// final result of each input word.
// An accepted word is registered in the input stage, evaluated against the scan
// state once the output queue holds two entries or fewer, and its results are
// written into a four-entry output queue, whose head drives the output channel.
// One input word is taken per cycle while the queue holds two entries or fewer;
// a header word that yields two results takes two queue entries.
// When the receiver stalls, the queue fills and in_ready drops until it drains.
// Reset clears the queue and the input stage and restores the registers and the
// scan state to their defaults. The APB port writes the flash size and the magic
// words; the user must do so only while the block is idle, which the block does
// not enforce. Writing the flash size restarts the scan.
module flash_firmware_partition_scanner_core
	import ffps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] flash_word,
	input  logic [31:0] fs_offset_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] base,
	output logic [31:0] length,
	output logic [31:0] image_end,
	output logic        last
);

	`include "flash_firmware_partition_scanner_core_assert.svh"

	logic [31:0] flash_bytes_q;
	logic [31:0] image_magic_q;
	logic [31:0] aux_first_q;
	logic [31:0] aux_second_q;

	logic [31:0] scan_offset_q;
	logic [31:0] image_start_q;
	logic [31:0] image_size_q;
	logic [31:0] region_size_q;
	logic [31:0] image_stop_q;
	logic        scan_found_q;
	logic        scan_done_q;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [31:0] word_s1;
	logic [31:0] fs_s1;

	result_t              queue_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;

	logic        cfg_wr;
	logic        proc;
	logic        pop;
	logic [1:0]  n_push;
	result_t     res0;
	result_t     res1;

	logic [31:0] offset_n;
	logic [31:0] start_n;
	logic [31:0] size_n;
	logic [31:0] region_n;
	logic [31:0] stop_n;
	logic        found_n;
	logic        done_n;
	logic        restart;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_FLASH_BYTES: prdata = flash_bytes_q;
			REG_IMAGE_MAGIC: prdata = image_magic_q;
			REG_AUX_FIRST:   prdata = aux_first_q;
			REG_AUX_SECOND:  prdata = aux_second_q;
			default:         prdata = 32'd0;
		endcase
	end

	assign proc     = valid_s1 && (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));
	assign in_ready = !valid_s1 || proc;
	assign pop      = out_valid && out_ready;

	always_comb begin
		logic [31:0] off;
		logic [31:0] next;
		logic [31:0] room;
		logic [31:0] size1;
		logic [31:0] slice_base;
		logic [31:0] slice_len;
		logic        aux_hit;
		off        = scan_offset_q;
		next       = off + SCAN_STEP;
		room       = 32'd0;
		size1      = image_size_q;
		slice_base = image_start_q + fs_s1;
		slice_len  = word_s1 - fs_s1;
		aux_hit    = (aux_first_q != 32'd0 && word_s1 == aux_first_q) ||
		             (aux_second_q != 32'd0 && word_s1 == aux_second_q);
		offset_n = scan_offset_q;
		start_n  = image_start_q;
		size_n   = image_size_q;
		region_n = region_size_q;
		stop_n   = image_stop_q;
		found_n  = scan_found_q;
		done_n   = scan_done_q;
		restart  = 1'b0;
		n_push   = 2'd0;
		res0     = '{kind: KIND_NOT_FOUND, base: 32'd0, length: 32'd0,
		             image_end: 32'd0, last: 1'b1};
		res1     = '{kind: KIND_CFG, base: (image_stop_q - CFG_SLICE_BYTES) & CFG_ALIGN_MASK,
		             length: CFG_SLICE_BYTES, image_end: 32'd0, last: 1'b1};
		case (mode_s1)
			MODE_SCAN: begin
				if (!scan_done_q) begin
					if (off >= region_size_q) begin
						done_n = 1'b1;
						n_push = 2'd1;
					end else begin
						if (image_start_q < off && image_size_q > off && aux_hit) begin
							size1 = off - image_start_q;
						end
						size_n = size1;
						if (image_magic_q != 32'd0 && word_s1 == image_magic_q &&
						    off >= image_start_q) begin
							region_n = off - image_start_q;
							room     = region_n - image_start_q;
							size_n   = (room < size1) ? room : size1;
							stop_n   = size_n + image_start_q;
							found_n  = 1'b1;
							done_n   = 1'b1;
							n_push   = 2'd1;
							res0     = '{kind: KIND_FOUND, base: image_start_q,
							             length: size_n, image_end: stop_n, last: 1'b1};
						end else begin
							if (image_magic_q != 32'd0 && word_s1 == image_magic_q) begin
								start_n = off;
							end
							offset_n = next;
							if (next < off || next >= region_size_q) begin
								done_n = 1'b1;
								n_push = 2'd1;
							end
						end
					end
				end
			end
			MODE_HEADER: begin
				n_push = 2'd1;
				if (!scan_found_q) begin
					res0.kind = KIND_NO_IMAGE;
				end else if ((fs_s1 & SECTOR_MASK) != 32'd0) begin
					res0.kind = KIND_MISALIGNED;
				end else begin
					res0 = '{kind: KIND_ROOTFS, base: slice_base, length: slice_len,
					         image_end: 32'd0, last: 1'b1};
					if ((word_s1 + CFG_SLICE_BYTES) <= image_size_q) begin
						res0.last = 1'b0;
						n_push    = 2'd2;
					end
				end
			end
			MODE_RESTART: begin
				restart = 1'b1;
			end
			default: begin
				n_push = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			word_s1 <= flash_word;
			fs_s1   <= fs_offset_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_bytes_q <= FLASH_BYTES_RST;
			image_magic_q <= 32'd0;
			aux_first_q   <= 32'd0;
			aux_second_q  <= 32'd0;
			scan_offset_q <= 32'd0;
			image_start_q <= NO_IMAGE_START;
			image_size_q  <= FLASH_BYTES_RST;
			region_size_q <= FLASH_BYTES_RST;
			image_stop_q  <= 32'd0;
			scan_found_q  <= 1'b0;
			scan_done_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FLASH_BYTES: begin
					flash_bytes_q <= pwdata;
					scan_offset_q <= 32'd0;
					image_start_q <= NO_IMAGE_START;
					image_size_q  <= pwdata;
					region_size_q <= pwdata;
					image_stop_q  <= 32'd0;
					scan_found_q  <= 1'b0;
					scan_done_q   <= 1'b0;
				end
				REG_IMAGE_MAGIC: image_magic_q <= pwdata;
				REG_AUX_FIRST:   aux_first_q   <= pwdata;
				REG_AUX_SECOND:  aux_second_q  <= pwdata;
				default:         image_magic_q <= image_magic_q;
			endcase
		end else if (proc) begin
			if (restart) begin
				scan_offset_q <= 32'd0;
				image_start_q <= NO_IMAGE_START;
				image_size_q  <= flash_bytes_q;
				region_size_q <= flash_bytes_q;
				image_stop_q  <= 32'd0;
				scan_found_q  <= 1'b0;
				scan_done_q   <= 1'b0;
			end else begin
				scan_offset_q <= offset_n;
				image_start_q <= start_n;
				image_size_q  <= size_n;
				region_size_q <= region_n;
				image_stop_q  <= stop_n;
				scan_found_q  <= found_n;
				scan_done_q   <= done_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			cnt_q <= cnt_q + (proc ? OUT_CNT_W'(n_push) : OUT_CNT_W'(0))
			               - (pop ? OUT_CNT_W'(1) : OUT_CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (proc && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (proc && n_push == 2'd2) begin
			queue_q[wr_ptr_q + OUT_PTR_W'(1)] <= res1;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign kind      = queue_q[rd_ptr_q].kind;
	assign base      = queue_q[rd_ptr_q].base;
	assign length    = queue_q[rd_ptr_q].length;
	assign image_end = queue_q[rd_ptr_q].image_end;
	assign last      = queue_q[rd_ptr_q].last;

	`FFPS_ASSERT_IMPLY(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= OUT_CNT_W'(OUT_DEPTH))
	`FFPS_ASSERT_IMPLY(a_found_is_done, clk, arst_n, scan_found_q, scan_done_q)
	`FFPS_ASSERT_NEXT(a_cfg_follows, clk, arst_n, out_valid && out_ready && !last,
		out_valid && kind == KIND_CFG)

endmodule

// ----- tb/ffps_result_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the scanner's result words and compares them with the output channel.
module ffps_result_checker
	import ffps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] flash_word,
	input  logic [31:0] fs_offset_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] base,
	input  logic [31:0] length,
	input  logic [31:0] image_end,
	input  logic        last,
	output int          errors,
	output int          pending
);

	logic [31:0] cfg_flash_bytes;
	logic [31:0] cfg_image_magic;
	logic [31:0] cfg_aux_first;
	logic [31:0] cfg_aux_second;

	logic [31:0] scan_offset;
	logic [31:0] image_start;
	logic [31:0] image_size;
	logic [31:0] region_size;
	logic [31:0] image_stop;
	logic        scan_found;
	logic        scan_done;

	result_t expected_words[$];
	result_t want;

	function automatic result_t make_result(input logic [2:0] k, input logic [31:0] b,
		input logic [31:0] l, input logic [31:0] e, input logic lst);
		result_t r;
		r.kind      = k;
		r.base      = b;
		r.length    = l;
		r.image_end = e;
		r.last      = lst;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic restart_scan();
		scan_offset = 32'd0;
		image_start = NO_IMAGE_START;
		image_size  = cfg_flash_bytes;
		region_size = cfg_flash_bytes;
		image_stop  = 32'd0;
		scan_found  = 1'b0;
		scan_done   = 1'b0;
	endtask

	task automatic predict_partition_results(input logic [1:0] m, input logic [31:0] w,
		input logic [31:0] fs);
		logic [31:0] off;
		logic [31:0] next;
		logic [31:0] room;
		logic [31:0] room_test;
		logic [31:0] cfg_base;
		case (m)
			MODE_SCAN: begin
				if (!scan_done) begin
					off = scan_offset;
					if (off >= region_size) begin
						scan_done = 1'b1;
						expected_words.push_back(make_result(KIND_NOT_FOUND, 0, 0, 0, 1'b1));
					end else begin
						if (image_start < off && image_size > off &&
							((cfg_aux_first != 0 && w == cfg_aux_first) ||
							(cfg_aux_second != 0 && w == cfg_aux_second)))
							image_size = off - image_start;
						if (cfg_image_magic != 0 && w == cfg_image_magic && off >= image_start) begin
							region_size = off - image_start;
							room = region_size - image_start;
							if (room < image_size)
								image_size = room;
							image_stop = image_size + image_start;
							scan_found = 1'b1;
							scan_done  = 1'b1;
							expected_words.push_back(make_result(KIND_FOUND, image_start,
								image_size, image_stop, 1'b1));
						end else begin
							if (cfg_image_magic != 0 && w == cfg_image_magic)
								image_start = off;
							next = off + SCAN_STEP;
							scan_offset = next;
							if (next < off || next >= region_size) begin
								scan_done = 1'b1;
								expected_words.push_back(make_result(KIND_NOT_FOUND, 0, 0, 0, 1'b1));
							end
						end
					end
				end
			end
			MODE_HEADER: begin
				room_test = w + CFG_SLICE_BYTES;
				if (!scan_found) begin
					expected_words.push_back(make_result(KIND_NO_IMAGE, 0, 0, 0, 1'b1));
				end else if ((fs & SECTOR_MASK) != 0) begin
					expected_words.push_back(make_result(KIND_MISALIGNED, 0, 0, 0, 1'b1));
				end else if (room_test > image_size) begin
					expected_words.push_back(make_result(KIND_ROOTFS, image_start + fs, w - fs,
						0, 1'b1));
				end else begin
					expected_words.push_back(make_result(KIND_ROOTFS, image_start + fs, w - fs,
						0, 1'b0));
					cfg_base = (image_stop - CFG_SLICE_BYTES) & CFG_ALIGN_MASK;
					expected_words.push_back(make_result(KIND_CFG, cfg_base, CFG_SLICE_BYTES,
						0, 1'b1));
				end
			end
			MODE_RESTART: begin
				restart_scan();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_flash_bytes = FLASH_BYTES_RST;
			cfg_image_magic = 32'd0;
			cfg_aux_first   = 32'd0;
			cfg_aux_second  = 32'd0;
			restart_scan();
			expected_words.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result word with nothing expected: kind %0d base %h",
						kind, base));
				end else begin
					want = expected_words.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind got %0d expected %0d", kind, want.kind));
					if (base !== want.base)
						report_mismatch($sformatf("base got %h expected %h", base, want.base));
					if (length !== want.length)
						report_mismatch($sformatf("length got %h expected %h", length, want.length));
					if (image_end !== want.image_end)
						report_mismatch($sformatf("image_end got %h expected %h", image_end,
							want.image_end));
					if (last !== want.last)
						report_mismatch($sformatf("last got %b expected %b", last, want.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FLASH_BYTES: begin
						cfg_flash_bytes = pwdata;
						restart_scan();
					end
					REG_IMAGE_MAGIC: cfg_image_magic = pwdata;
					REG_AUX_FIRST:   cfg_aux_first   = pwdata;
					REG_AUX_SECOND:  cfg_aux_second  = pwdata;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				predict_partition_results(mode, flash_word, fs_offset_word);
			pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/tb_flash_firmware_partition_scanner_core.sv -----
`timescale 1ns / 1ps
// Testbench top that drives the flash firmware partition scanner and reports the verdict.
module tb_flash_firmware_partition_scanner_core;
	import ffps_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 250;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [3:0]  paddr          = 4'd0;
	logic [31:0] pwdata         = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [1:0]  mode           = MODE_SCAN;
	logic [31:0] flash_word     = 32'd0;
	logic [31:0] fs_offset_word = 32'd0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [2:0]  kind;
	logic [31:0] base;
	logic [31:0] length;
	logic [31:0] image_end;
	logic        last;

	int errors;
	int pending;
	int send_idle_pct = 34;
	int recv_idle_pct = 62;
	int words_sent    = 0;
	int quiet_cycles  = 0;

	logic [31:0] cur_flash      = FLASH_BYTES_RST;
	logic [31:0] cur_magic      = 32'd0;
	logic [31:0] cur_aux_first  = 32'd0;
	logic [31:0] cur_aux_second = 32'd0;

	flash_firmware_partition_scanner_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.flash_word     (flash_word),
		.fs_offset_word (fs_offset_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.base           (base),
		.length         (length),
		.image_end      (image_end),
		.last           (last)
	);

	ffps_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.flash_word     (flash_word),
		.fs_offset_word (fs_offset_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.base           (base),
		.length         (length),
		.image_end      (image_end),
		.last           (last),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [1:0] m, input logic [31:0] w, input logic [31:0] fs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= m;
		flash_word     <= w;
		fs_offset_word <= fs;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] flash, input logic [31:0] magic,
		input logic [31:0] aux_first, input logic [31:0] aux_second);
		settle();
		apb_write(REG_FLASH_BYTES, flash);
		apb_write(REG_IMAGE_MAGIC, magic);
		apb_write(REG_AUX_FIRST, aux_first);
		apb_write(REG_AUX_SECOND, aux_second);
		cur_flash      = flash;
		cur_magic      = magic;
		cur_aux_first  = aux_first;
		cur_aux_second = aux_second;
	endtask

	task automatic run_phase(input int count);
		int target;
		int start_at;
		int gap;
		int n;
		int pick;
		logic [31:0] w;
		logic [31:0] fs;
		logic [31:0] len;
		target = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick >= 8 && cur_flash > 70 * SCAN_STEP)
				pick = 0;
			case (pick)
				6: begin
					send_word(MODE_RESTART, $urandom, $urandom);
					n = $urandom_range(0, 6);
					for (int i = 0; i < n; i++)
						send_word(MODE_SCAN, (i == 0 && $urandom_range(0, 1)) ? cur_magic : $urandom,
							$urandom);
					send_word(MODE_HEADER, $urandom, $urandom);
				end
				7: begin
					n = $urandom_range(5, 12);
					repeat (n) begin
						w = ($urandom_range(0, 3) == 0) ? cur_magic : $urandom;
						send_word(2'($urandom_range(0, 3)), w, $urandom);
					end
				end
				8, 9: begin
					send_word(MODE_RESTART, $urandom, $urandom);
					n = int'((64'(cur_flash) + SCAN_STEP - 1) / SCAN_STEP);
					for (int i = 0; i <= n; i++)
						send_word(MODE_SCAN, (i == 0 && $urandom_range(0, 1)) ? cur_magic : $urandom,
							$urandom);
					send_word(MODE_HEADER, $urandom, $urandom);
				end
				default: begin
					start_at = $urandom_range(0, 4);
					gap = $urandom_range(2, 40);
					send_word(MODE_RESTART, $urandom, $urandom);
					for (int i = 0; i <= start_at + gap; i++) begin
						if (i == start_at || i == start_at + gap)
							w = cur_magic;
						else if (i > start_at && $urandom_range(0, 7) == 0)
							w = $urandom_range(0, 1) ? cur_aux_first : cur_aux_second;
						else
							w = $urandom;
						send_word(MODE_SCAN, w, $urandom);
					end
					n = $urandom_range(1, 3);
					repeat (n) begin
						case ($urandom_range(0, 4))
							0: begin
								fs = $urandom;
								if ((fs & SECTOR_MASK) == 0)
									fs[0] = 1'b1;
							end
							1: fs = $urandom & ~SECTOR_MASK;
							default: fs = 32'($urandom_range(0, 127)) << 9;
						endcase
						case ($urandom_range(0, 3))
							0: len = $urandom;
							1: len = 32'hFFFF_0000 + 32'($urandom_range(0, 32'h1FFFF));
							default: len = 32'($urandom_range(0, 32'h30000));
						endcase
						send_word(MODE_HEADER, len, fs);
					end
					if ($urandom_range(0, 2) == 0)
						send_word(MODE_SCAN, cur_magic, $urandom);
				end
			endcase
			if ($urandom_range(0, 29) == 0)
				settle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(MODE_HEADER, 32'd0, 32'd0);
		send_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(MODE_SCAN, 32'd0, 32'd0);

		configure(32'd0, 32'd0, 32'd0, 32'd0);
		send_word(MODE_SCAN, 32'hFFFF_FFFF, 32'd0);
		send_word(MODE_SCAN, 32'd0, 32'd0);

		configure(8 * SCAN_STEP, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0);
		send_word(MODE_RESTART, 32'd0, 32'd0);
		send_word(MODE_SCAN, 32'hFFFF_FFFF, 32'd0);
		send_word(MODE_SCAN, 32'd0, 32'hFFFF_FFFF);
		send_word(MODE_SCAN, 32'h1234_5678, 32'd0);
		send_word(MODE_SCAN, 32'hFFFF_FFFF, 32'd0);
		send_word(MODE_HEADER, 32'd0, 32'd0);
		send_word(MODE_HEADER, $urandom, 32'h0000_0100);
		send_word(MODE_HEADER, 32'hFFFF_FFFF, 32'hFFFF_FE00);
		send_word(MODE_HEADER, 32'hFFFF_0000, 32'd0);
		send_word(MODE_SCAN, 32'hFFFF_FFFF, 32'd0);
		send_word(MODE_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (8) send_word(MODE_SCAN, $urandom & 32'h7FFF_FFFF, $urandom);

		configure(64 * SCAN_STEP, $urandom | 32'd1, $urandom | 32'd1, $urandom | 32'd1);
		run_phase(PHASE_WORDS);

		send_idle_pct = 62;
		recv_idle_pct = 34;
		configure(48 * SCAN_STEP + 32'($urandom_range(1, 4095)), 32'hFFFF_FFFF, 32'd0,
			$urandom | 32'd1);
		run_phase(PHASE_WORDS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(32'hFFFF_FFFF, $urandom | 32'd1, 32'hFFFF_FFFF, $urandom | 32'd1);
		run_phase(PHASE_WORDS);

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ffps_pkg.sv
sv/flash_firmware_partition_scanner_core.sv
tb/ffps_result_checker.sv
tb/tb_flash_firmware_partition_scanner_core.sv
